>>> hw/rtl/cse_pkg.sv
package cse_pkg;

    // sample and accumulator sizing
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_LEN     = 1024;
    localparam int MAG_W       = SAMPLE_BITS;
    localparam int SQ_W        = 2 * SAMPLE_BITS + $clog2(MAX_LEN);
    localparam int DOT_W       = SQ_W + 1;

    // shared multiplier
    localparam int OP_W    = 32;
    localparam int PROD_W  = 2 * OP_W;
    localparam int SHIFT_W = 6;

    // wide products for the final compare
    localparam int P_W   = 2 * SQ_W;
    localparam int R_W   = 2 * (DOT_W - 1) + 1;
    localparam int ACC_W = R_W + 32;

    // limb splits used by the sequencer
    localparam int P_LIMB = SQ_W / 2;
    localparam int R_LIMB = 22;
    localparam int Q_LIMB = 28;

    // result
    localparam int Q_W   = 16;
    localparam int BIT_W = 4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ELEM,
        ST_ELEM_WAIT,
        ST_ZCHK,
        ST_PMUL,
        ST_PWAIT,
        ST_PSAVE,
        ST_RMUL,
        ST_RWAIT,
        ST_RSAVE,
        ST_BTEST,
        ST_TWAIT,
        ST_QMUL,
        ST_QWAIT,
        ST_QCMP,
        ST_DONE
    } state_t;

    // what to do with a product when it comes out of the multiplier
    typedef enum logic [2:0] {
        MOP_DOT,
        MOP_SQA,
        MOP_SQB,
        MOP_ACC,
        MOP_T2
    } mul_op_t;

    typedef struct packed {
        logic              issue;
        mul_op_t           op;
        logic [SHIFT_W-1:0] shift;
        logic              neg;
        logic [OP_W-1:0]   x;
        logic [OP_W-1:0]   y;
    } mul_cmd_t;

    typedef struct packed {
        logic               valid;
        mul_op_t            op;
        logic [SHIFT_W-1:0] shift;
        logic               neg;
        logic [PROD_W-1:0]  product;
    } mul_res_t;

endpackage

>>> hw/rtl/cse_mul.sv
module cse_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  cse_pkg::mul_cmd_t cmd,
    output cse_pkg::mul_res_t res
);
    import cse_pkg::*;

    logic              valid_reg;
    mul_op_t           op_reg;
    logic [SHIFT_W-1:0] shift_reg;
    logic              neg_reg;
    logic [PROD_W-1:0] product_reg;
    logic [PROD_W-1:0] product_next;

    // one unsigned 32x32 multiply per cycle
    always_comb
    begin
        product_next = product_reg;
        if (cmd.issue)
        begin
            product_next = cmd.x * cmd.y;
        end
    end

    // tag valid travels with the product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.issue;
        end
    end

    // product and its tag
    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
        if (cmd.issue)
        begin
            op_reg    <= cmd.op;
            shift_reg <= cmd.shift;
            neg_reg   <= cmd.neg;
        end
    end

    assign res.valid   = valid_reg;
    assign res.op      = op_reg;
    assign res.shift   = shift_reg;
    assign res.neg     = neg_reg;
    assign res.product = product_reg;

endmodule

>>> hw/rtl/cosine_similarity_engine_top.sv
// channel | signals                                  | word
// --------+------------------------------------------+-----------------------------------
// in      | in_valid, in_stall, elem_a, elem_b,      | one element pair, last marks the
//         | last_element                             | final pair of both vectors
// out     | out_valid, out_stall, similarity,        | one Q1.15 similarity per vector
//         | zero_input                               | pair, flag for a zero vector
//
// a word not marked last is accepted and then makes three passes through the shared
// 32x32 multiplier (a*b, a*a, b*b); a marked word makes the same passes, then aa*bb
// and dot*dot in limbs, then 16 bit tests (t*t, three limb products, a compare); a zero
// vector ends at the zero check and a full-scale match once the top bit is kept;
// in_stall is high while a word works. reset clears sums and sequencer; a result held
// by out_stall still lets unmarked words in.
module cosine_similarity_engine_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [cse_pkg::MAG_W-1:0]    elem_a,
    input  logic signed [cse_pkg::MAG_W-1:0]    elem_b,
    input  logic                                last_element,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [cse_pkg::Q_W-1:0]      similarity,
    output logic                                zero_input
);
    import cse_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic [1:0] step_reg;
    logic [1:0] step_next;

    logic [MAG_W-1:0] a_mag_reg, a_mag_next;
    logic [MAG_W-1:0] b_mag_reg, b_mag_next;
    logic             neg_reg, neg_next;
    logic             last_reg, last_next;
    logic             zero_reg, zero_next;

    logic signed [DOT_W-1:0] dot_sum_reg, dot_sum_next;
    logic [SQ_W-1:0]         a_square_sum_reg, a_square_sum_next;
    logic [SQ_W-1:0]         b_square_sum_reg, b_square_sum_next;

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [P_W-1:0]   p_reg, p_next;
    logic [R_W-1:0]   r_reg, r_next;
    logic [OP_W-1:0]  t2_reg, t2_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic [BIT_W-1:0] bit_reg, bit_next;

    logic                    out_valid_reg, out_valid_next;
    logic signed [Q_W-1:0]   similarity_reg, similarity_next;
    logic                    zero_input_reg, zero_input_next;

    mul_cmd_t mul_cmd;
    mul_res_t mul_res;

    logic               in_accept;
    logic               out_free;
    logic [DOT_W-1:0]   dot_mag;
    logic [Q_W-1:0]     cand;
    logic [Q_W-1:0]     t_val;
    logic               fit;
    logic               acc_clear;
    logic               load_out;
    logic [DOT_W+1:0]   dot_ext;
    logic [DOT_W+1:0]   dot_term;
    logic [DOT_W+1:0]   dot_wide;
    logic [SQ_W:0]      sq_wide;
    logic [2*MAG_W-1:0] prod_small;
    logic signed [Q_W-1:0] result_val;

    // shared multiplier
    cse_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mul_cmd),
        .res   (mul_res)
    );

    // handshake helpers
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // magnitude of the dot product, candidate quotient and its odd square root term
    assign dot_mag = dot_sum_reg[DOT_W-1] ? DOT_W'(-dot_sum_reg) : DOT_W'(dot_sum_reg);
    assign cand    = q_reg | (Q_W'(1) << bit_reg);
    assign t_val   = Q_W'({cand, 1'b0} - (Q_W+1)'(1));
    assign fit     = (acc_reg <= {r_reg, 32'b0});

    // signed result from the bit search
    always_comb
    begin
        if (zero_reg)
        begin
            result_val = '0;
        end
        else if (dot_sum_reg[DOT_W-1])
        begin
            result_val = $signed(Q_W'(-q_reg));
        end
        else if (q_reg[Q_W-1])
        begin
            result_val = $signed({1'b0, {(Q_W-1){1'b1}}});
        end
        else
        begin
            result_val = $signed(q_reg);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (in_accept)
                begin
                    state_next = ST_ELEM;
                end
            end
            ST_ELEM:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd2)
                begin
                    step_next  = '0;
                    state_next = last_reg ? ST_ELEM_WAIT : ST_IDLE;
                end
            end
            ST_ELEM_WAIT:
            begin
                state_next = ST_ZCHK;
            end
            ST_ZCHK:
            begin
                if (a_square_sum_reg == '0 || b_square_sum_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_PMUL;
                end
            end
            ST_PMUL:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    step_next  = '0;
                    state_next = ST_PWAIT;
                end
            end
            ST_PWAIT:
            begin
                state_next = ST_PSAVE;
            end
            ST_PSAVE:
            begin
                state_next = ST_RMUL;
            end
            ST_RMUL:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd2)
                begin
                    step_next  = '0;
                    state_next = ST_RWAIT;
                end
            end
            ST_RWAIT:
            begin
                state_next = ST_RSAVE;
            end
            ST_RSAVE:
            begin
                state_next = ST_BTEST;
            end
            ST_BTEST:
            begin
                state_next = q_reg[Q_W-1] ? ST_DONE : ST_TWAIT;
            end
            ST_TWAIT:
            begin
                state_next = ST_QMUL;
            end
            ST_QMUL:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd2)
                begin
                    step_next  = '0;
                    state_next = ST_QWAIT;
                end
            end
            ST_QWAIT:
            begin
                state_next = ST_QCMP;
            end
            ST_QCMP:
            begin
                state_next = (bit_reg == '0) ? ST_DONE : ST_BTEST;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs: multiplier commands and strobes
    always_comb
    begin
        mul_cmd       = '0;
        mul_cmd.op    = MOP_ACC;
        acc_clear     = 1'b0;
        load_out      = 1'b0;
        unique case (state_reg)
            ST_ELEM:
            begin
                mul_cmd.issue = 1'b1;
                case (step_reg)
                    2'd0:
                    begin
                        mul_cmd.op  = MOP_DOT;
                        mul_cmd.neg = neg_reg;
                        mul_cmd.x   = OP_W'(a_mag_reg);
                        mul_cmd.y   = OP_W'(b_mag_reg);
                    end
                    2'd1:
                    begin
                        mul_cmd.op = MOP_SQA;
                        mul_cmd.x  = OP_W'(a_mag_reg);
                        mul_cmd.y  = OP_W'(a_mag_reg);
                    end
                    default:
                    begin
                        mul_cmd.op = MOP_SQB;
                        mul_cmd.x  = OP_W'(b_mag_reg);
                        mul_cmd.y  = OP_W'(b_mag_reg);
                    end
                endcase
            end
            ST_ZCHK:
            begin
                acc_clear = 1'b1;
            end
            ST_PMUL:
            begin
                // aa * bb from 21-bit limbs
                mul_cmd.issue = 1'b1;
                case (step_reg)
                    2'd0:
                    begin
                        mul_cmd.x     = OP_W'(a_square_sum_reg[P_LIMB-1:0]);
                        mul_cmd.y     = OP_W'(b_square_sum_reg[P_LIMB-1:0]);
                        mul_cmd.shift = '0;
                    end
                    2'd1:
                    begin
                        mul_cmd.x     = OP_W'(a_square_sum_reg[P_LIMB-1:0]);
                        mul_cmd.y     = OP_W'(b_square_sum_reg[SQ_W-1:P_LIMB]);
                        mul_cmd.shift = SHIFT_W'(P_LIMB);
                    end
                    2'd2:
                    begin
                        mul_cmd.x     = OP_W'(a_square_sum_reg[SQ_W-1:P_LIMB]);
                        mul_cmd.y     = OP_W'(b_square_sum_reg[P_LIMB-1:0]);
                        mul_cmd.shift = SHIFT_W'(P_LIMB);
                    end
                    default:
                    begin
                        mul_cmd.x     = OP_W'(a_square_sum_reg[SQ_W-1:P_LIMB]);
                        mul_cmd.y     = OP_W'(b_square_sum_reg[SQ_W-1:P_LIMB]);
                        mul_cmd.shift = SHIFT_W'(2 * P_LIMB);
                    end
                endcase
            end
            ST_PSAVE:
            begin
                acc_clear = 1'b1;
            end
            ST_RMUL:
            begin
                // dot * dot, the cross term counted twice by one more shift
                mul_cmd.issue = 1'b1;
                case (step_reg)
                    2'd0:
                    begin
                        mul_cmd.x     = OP_W'(dot_mag[R_LIMB-1:0]);
                        mul_cmd.y     = OP_W'(dot_mag[R_LIMB-1:0]);
                        mul_cmd.shift = '0;
                    end
                    2'd1:
                    begin
                        mul_cmd.x     = OP_W'(dot_mag[R_LIMB-1:0]);
                        mul_cmd.y     = OP_W'(dot_mag[DOT_W-1:R_LIMB]);
                        mul_cmd.shift = SHIFT_W'(R_LIMB + 1);
                    end
                    default:
                    begin
                        mul_cmd.x     = OP_W'(dot_mag[DOT_W-1:R_LIMB]);
                        mul_cmd.y     = OP_W'(dot_mag[DOT_W-1:R_LIMB]);
                        mul_cmd.shift = SHIFT_W'(2 * R_LIMB);
                    end
                endcase
            end
            ST_BTEST:
            begin
                if (!q_reg[Q_W-1])
                begin
                    mul_cmd.issue = 1'b1;
                    mul_cmd.op    = MOP_T2;
                    mul_cmd.x     = OP_W'(t_val);
                    mul_cmd.y     = OP_W'(t_val);
                end
            end
            ST_TWAIT:
            begin
                acc_clear = 1'b1;
            end
            ST_QMUL:
            begin
                // aa*bb times t*t from 28-bit limbs
                mul_cmd.issue = 1'b1;
                mul_cmd.y     = t2_reg;
                case (step_reg)
                    2'd0:
                    begin
                        mul_cmd.x     = OP_W'(p_reg[Q_LIMB-1:0]);
                        mul_cmd.shift = '0;
                    end
                    2'd1:
                    begin
                        mul_cmd.x     = OP_W'(p_reg[2*Q_LIMB-1:Q_LIMB]);
                        mul_cmd.shift = SHIFT_W'(Q_LIMB);
                    end
                    default:
                    begin
                        mul_cmd.x     = OP_W'(p_reg[P_W-1:2*Q_LIMB]);
                        mul_cmd.shift = SHIFT_W'(2 * Q_LIMB);
                    end
                endcase
            end
            ST_DONE:
            begin
                load_out = out_free;
            end
            default:
            begin
                mul_cmd.issue = 1'b0;
            end
        endcase
    end

    // product consumers and datapath registers
    always_comb
    begin
        a_mag_next        = a_mag_reg;
        b_mag_next        = b_mag_reg;
        neg_next          = neg_reg;
        last_next         = last_reg;
        zero_next         = zero_reg;
        dot_sum_next      = dot_sum_reg;
        a_square_sum_next = a_square_sum_reg;
        b_square_sum_next = b_square_sum_reg;
        acc_next          = acc_reg;
        p_next            = p_reg;
        r_next            = r_reg;
        t2_next           = t2_reg;
        q_next            = q_reg;
        bit_next          = bit_reg;
        out_valid_next    = out_valid_reg;
        similarity_next   = similarity_reg;
        zero_input_next   = zero_input_reg;

        prod_small = mul_res.product[2*MAG_W-1:0];
        dot_ext    = {{2{dot_sum_reg[DOT_W-1]}}, dot_sum_reg};
        dot_term   = mul_res.neg ? (DOT_W+2)'(-{1'b0, prod_small})
                                 : (DOT_W+2)'(prod_small);
        dot_wide   = dot_ext + dot_term;
        sq_wide    = '0;

        // latch the element pair
        if (in_accept)
        begin
            a_mag_next = elem_a[MAG_W-1] ? MAG_W'(-elem_a) : MAG_W'(elem_a);
            b_mag_next = elem_b[MAG_W-1] ? MAG_W'(-elem_b) : MAG_W'(elem_b);
            neg_next   = elem_a[MAG_W-1] ^ elem_b[MAG_W-1];
            last_next  = last_element;
        end

        // consume the product of the previous cycle
        if (mul_res.valid)
        begin
            case (mul_res.op)
                MOP_DOT:
                begin
                    if (dot_wide[DOT_W+1:DOT_W-1] != 3'b000 &&
                        dot_wide[DOT_W+1:DOT_W-1] != 3'b111)
                    begin
                        dot_sum_next = dot_wide[DOT_W+1] ? $signed({1'b1, {(DOT_W-1){1'b0}}})
                                                         : $signed({1'b0, {(DOT_W-1){1'b1}}});
                    end
                    else
                    begin
                        dot_sum_next = $signed(dot_wide[DOT_W-1:0]);
                    end
                end
                MOP_SQA:
                begin
                    sq_wide           = (SQ_W+1)'(a_square_sum_reg) + (SQ_W+1)'(prod_small);
                    a_square_sum_next = sq_wide[SQ_W] ? {SQ_W{1'b1}} : sq_wide[SQ_W-1:0];
                end
                MOP_SQB:
                begin
                    sq_wide           = (SQ_W+1)'(b_square_sum_reg) + (SQ_W+1)'(prod_small);
                    b_square_sum_next = sq_wide[SQ_W] ? {SQ_W{1'b1}} : sq_wide[SQ_W-1:0];
                end
                MOP_ACC:
                begin
                    acc_next = acc_reg + (ACC_W'(mul_res.product) << mul_res.shift);
                end
                MOP_T2:
                begin
                    t2_next = mul_res.product[OP_W-1:0];
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end

        if (acc_clear)
        begin
            acc_next = '0;
        end

        // zero vector check and save of the wide products
        if (state_reg == ST_ZCHK)
        begin
            zero_next = (a_square_sum_reg == '0 || b_square_sum_reg == '0);
        end
        if (state_reg == ST_PSAVE)
        begin
            p_next = acc_reg[P_W-1:0];
        end
        if (state_reg == ST_RSAVE)
        begin
            r_next   = acc_reg[R_W-1:0];
            q_next   = '0;
            bit_next = BIT_W'(Q_W - 1);
        end

        // keep the candidate bit when the scaled square fits
        if (state_reg == ST_QCMP)
        begin
            if (fit)
            begin
                q_next = cand;
            end
            bit_next = bit_reg - BIT_W'(1);
        end

        // output register
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next    = 1'b1;
            similarity_next   = result_val;
            zero_input_next   = zero_reg;
            dot_sum_next      = '0;
            a_square_sum_next = '0;
            b_square_sum_next = '0;
        end
    end

    // control and sum registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            out_valid_reg    <= 1'b0;
            dot_sum_reg      <= '0;
            a_square_sum_reg <= '0;
            b_square_sum_reg <= '0;
            last_reg         <= 1'b0;
            zero_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            out_valid_reg    <= out_valid_next;
            dot_sum_reg      <= dot_sum_next;
            a_square_sum_reg <= a_square_sum_next;
            b_square_sum_reg <= b_square_sum_next;
            last_reg         <= last_next;
            zero_reg         <= zero_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        a_mag_reg      <= a_mag_next;
        b_mag_reg      <= b_mag_next;
        neg_reg        <= neg_next;
        acc_reg        <= acc_next;
        p_reg          <= p_next;
        r_reg          <= r_next;
        t2_reg         <= t2_next;
        q_reg          <= q_next;
        bit_reg        <= bit_next;
        similarity_reg <= similarity_next;
        zero_input_reg <= zero_input_next;
    end

    assign out_valid  = out_valid_reg;
    assign similarity = similarity_reg;
    assign zero_input = zero_input_reg;

endmodule

>>> hw/rtl/cse_checker.sv
module cse_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic signed [cse_pkg::Q_W-1:0]   similarity,
    input logic                             zero_input
);
    import cse_pkg::*;

    // a held word does not change while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(similarity) && $stable(zero_input))
        else $error("output word changed while stalled");

    // a zero vector always reports zero similarity
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_input |-> similarity == '0)
        else $error("zero vector flag with nonzero similarity");

    // the block is busy in the cycle after it takes a word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after a word");

    // a new result only appears after the block has been busy
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without sequencer work");

endmodule

bind cosine_similarity_engine_top cse_checker u_cse_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .similarity (similarity),
    .zero_input (zero_input)
);
